// ===== rtl/triangle_plane_splitter_macros.svh =====
// Assertion macros used by the triangle plane splitter output stage.
`ifndef TRIANGLE_PLANE_SPLITTER_MACROS_SVH
`define TRIANGLE_PLANE_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tsp assertion failed");
`define TSP_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tsp assertion failed");
`else
`define TSP_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define TSP_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/tsp_pkg.sv =====
// Package: shared types, constants and helpers of the triangle plane splitter.
`timescale 1ns / 1ps
package tsp_pkg;
    localparam int COORD_W    = 32;
    localparam int NORM_W     = 16;
    localparam int OFFS_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OFFS_SHIFT = 14;
    localparam int PROD_W     = COORD_W + NORM_W;
    localparam int DIST_W     = PROD_W + 2;
    localparam int DEN_W      = DIST_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MUL_W      = DIFF_W + FRAC_BITS + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [OFFS_W-1:0]  offs_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    localparam norm_t NZ_RESET = NORM_W'(16384);
    localparam logic [FRAC_BITS-1:0] T_MIN = FRAC_BITS'(1);
    localparam logic [FRAC_BITS-1:0] T_MAX = '1;

    typedef enum logic [1:0] {REG_NX, REG_NY, REG_NZ, REG_OFFSET} reg_idx_t;

    // number of begin-side vertices
    typedef enum logic [1:0] {SPLIT_NONE, SPLIT_ONE, SPLIT_TWO, SPLIT_ALL} split_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vert_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
    } in_t;

    typedef struct packed {
        logic   side;
        coord_t out_a_x;
        coord_t out_a_y;
        coord_t out_a_z;
        coord_t out_b_x;
        coord_t out_b_y;
        coord_t out_b_z;
        coord_t out_c_x;
        coord_t out_c_y;
        coord_t out_c_z;
        logic   last;
    } out_t;

    typedef struct packed {
        norm_t plane_nx;
        norm_t plane_ny;
        norm_t plane_nz;
        offs_t plane_offset;
    } cfg_t;

    // s0..s2: begin vertices first, then end vertices, arrival order kept
    typedef struct packed {
        split_t split;
        vert_t  s0;
        vert_t  s1;
        vert_t  s2;
    } ctx_t;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [FRAC_BITS-1:0] q;
        logic                 de_zero;
    } cut_t;

    typedef struct packed {
        split_t split;
        vert_t  s0;
        vert_t  s1;
        vert_t  s2;
        vert_t  i1;
        vert_t  i2;
    } bundle_t;

    function automatic vert_t mk_vert(coord_t x, coord_t y, coord_t z);
        vert_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction
endpackage

// ===== rtl/triangle_plane_splitter.sv =====
// Top level of the triangle plane splitter: register port and pipeline wiring.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one triangle per beat,
//   three vertices of signed Q16.16 x, y, z. Output channel (out_valid /
//   out_stall / out_data) returns the pieces, each tagged with its side, with
//   last set on the final piece of an input triangle.
//   A triangle wholly on one side gives one beat; a crossing one gives three.
//   Pipeline: 15 registers between input and output, namely 3 distance
//   stages, 8 divider stages at two quotient bits each, 3 interpolation
//   stages and 1 output hold register.
//   Throughput: one beat per cycle on the output unless out_stall is high;
//   a new triangle enters every unstalled cycle while pieces are single;
//   a split holds entry while the single output register sends three pieces.
//   Receiver stall: the output beat holds and the whole pipeline freezes;
//   in_stall rises, nothing is dropped or repeated.
//   Reset: pipeline empties, plane resets to normal (0, 0, 1.0), offset 0.
//   User must write plane registers via APB only while idle; block won't check.
module triangle_plane_splitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [tsp_pkg::DATA_W-1:0]    pwdata,
    output logic [tsp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tsp_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tsp_pkg::out_t                 out_data
);
    import tsp_pkg::*;

    // plane registers
    norm_t    nx_reg;
    norm_t    ny_reg;
    norm_t    nz_reg;
    offs_t    offset_reg;
    logic     wr_en;
    reg_idx_t wr_idx;
    cfg_t     cfg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg     <= '0;
            ny_reg     <= '0;
            nz_reg     <= NZ_RESET;
            offset_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_NX:     nx_reg     <= norm_t'(pwdata[NORM_W-1:0]);
                REG_NY:     ny_reg     <= norm_t'(pwdata[NORM_W-1:0]);
                REG_NZ:     nz_reg     <= norm_t'(pwdata[NORM_W-1:0]);
                REG_OFFSET: offset_reg <= offs_t'(pwdata[OFFS_W-1:0]);
            endcase
        end
    end

    // read back, zero-extended
    always_comb
    begin
        unique case (wr_idx)
            REG_NX:     prdata = {{(DATA_W-NORM_W){1'b0}}, nx_reg};
            REG_NY:     prdata = {{(DATA_W-NORM_W){1'b0}}, ny_reg};
            REG_NZ:     prdata = {{(DATA_W-NORM_W){1'b0}}, nz_reg};
            REG_OFFSET: prdata = DATA_W'(offset_reg);
        endcase
    end

    assign cfg.plane_nx     = nx_reg;
    assign cfg.plane_ny     = ny_reg;
    assign cfg.plane_nz     = nz_reg;
    assign cfg.plane_offset = offset_reg;

    // pipeline advances as one; the output stage decides
    logic    adv;
    logic    dist_valid;
    ctx_t    dist_ctx;
    cut_t    dist_cut1;
    cut_t    dist_cut2;
    logic    div_valid;
    ctx_t    div_ctx;
    cut_t    div_cut1;
    cut_t    div_cut2;
    logic    bundle_valid;
    bundle_t bundle;

    assign in_stall = !adv;

    tsp_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cfg       (cfg),
        .ctx_valid (dist_valid),
        .ctx       (dist_ctx),
        .cut1      (dist_cut1),
        .cut2      (dist_cut2)
    );

    tsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dist_valid),
        .in_ctx    (dist_ctx),
        .in_cut1   (dist_cut1),
        .in_cut2   (dist_cut2),
        .out_valid (div_valid),
        .out_ctx   (div_ctx),
        .out_cut1  (div_cut1),
        .out_cut2  (div_cut2)
    );

    tsp_interp u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (div_valid),
        .in_ctx       (div_ctx),
        .in_cut1      (div_cut1),
        .in_cut2      (div_cut2),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    tsp_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_valid (bundle_valid),
        .bundle       (bundle),
        .out_stall    (out_stall),
        .adv          (adv),
        .out_valid    (out_valid),
        .out_data     (out_data)
    );
endmodule

// ===== rtl/tsp_dist.sv =====
// Plane distance and classification: products, sums, partition and divider setup.
`timescale 1ns / 1ps
module tsp_dist (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  tsp_pkg::in_t  in_data,
    input  tsp_pkg::cfg_t cfg,
    output logic          ctx_valid,
    output tsp_pkg::ctx_t ctx,
    output tsp_pkg::cut_t cut1,
    output tsp_pkg::cut_t cut2
);
    import tsp_pkg::*;

    function automatic logic signed [PROD_W-1:0] mul_cn(coord_t c, norm_t n);
        logic signed [PROD_W-1:0] ce;
        logic signed [PROD_W-1:0] ne;
        ce = PROD_W'(c);
        ne = PROD_W'(n);
        return ce * ne;
    endfunction

    function automatic cut_t mk_cut(dist_t db, dist_t de);
        cut_t c;
        logic signed [DEN_W-1:0] b;
        logic signed [DEN_W-1:0] e;
        b = DEN_W'(db);
        e = DEN_W'(de);
        c.rem     = DEN_W'(0) - b;
        c.den     = e - b;
        c.q       = '0;
        c.de_zero = (de == '0);
        return c;
    endfunction

    // stage 1: products
    logic                     s1_valid_reg;
    vert_t                    v1_reg [3];
    logic signed [PROD_W-1:0] p1_reg [3][3];
    dist_t                    off1_reg;
    vert_t                    v_in [3];
    logic signed [PROD_W-1:0] p1_next [3][3];
    dist_t                    off1_next;

    always_comb
    begin
        v_in[0] = mk_vert(in_data.a_x, in_data.a_y, in_data.a_z);
        v_in[1] = mk_vert(in_data.b_x, in_data.b_y, in_data.b_z);
        v_in[2] = mk_vert(in_data.c_x, in_data.c_y, in_data.c_z);
        for (int i = 0; i < 3; i++)
        begin
            p1_next[i][0] = mul_cn(v_in[i].x, cfg.plane_nx);
            p1_next[i][1] = mul_cn(v_in[i].y, cfg.plane_ny);
            p1_next[i][2] = mul_cn(v_in[i].z, cfg.plane_nz);
        end
        off1_next = dist_t'(cfg.plane_offset) <<< OFFS_SHIFT;
    end

    // stage 2: sums
    logic  s2_valid_reg;
    vert_t v2_reg [3];
    dist_t d2_reg [3];
    dist_t d2_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d2_next[i] = dist_t'(p1_reg[i][0]) + dist_t'(p1_reg[i][1])
                       + dist_t'(p1_reg[i][2]) + off1_reg;
        end
    end

    // stage 3: partition, divider operands
    logic       s3_valid_reg;
    ctx_t       ctx_reg;
    cut_t       cut1_reg;
    cut_t       cut2_reg;
    ctx_t       ctx_next;
    cut_t       cut1_next;
    cut_t       cut2_next;
    logic [2:0] neg;
    dist_t      sd0;
    dist_t      sd1;
    dist_t      sd2;

    always_comb
    begin
        neg = {d2_reg[2][DIST_W-1], d2_reg[1][DIST_W-1], d2_reg[0][DIST_W-1]};
        ctx_next.s0 = v2_reg[0];
        ctx_next.s1 = v2_reg[1];
        ctx_next.s2 = v2_reg[2];
        sd0 = d2_reg[0];
        sd1 = d2_reg[1];
        sd2 = d2_reg[2];
        unique case (neg)
            3'b000: ctx_next.split = SPLIT_NONE;
            3'b001: ctx_next.split = SPLIT_ONE;
            3'b010:
            begin
                ctx_next.split = SPLIT_ONE;
                ctx_next.s0 = v2_reg[1];
                ctx_next.s1 = v2_reg[0];
                sd0 = d2_reg[1];
                sd1 = d2_reg[0];
            end
            3'b100:
            begin
                ctx_next.split = SPLIT_ONE;
                ctx_next.s0 = v2_reg[2];
                ctx_next.s1 = v2_reg[0];
                ctx_next.s2 = v2_reg[1];
                sd0 = d2_reg[2];
                sd1 = d2_reg[0];
                sd2 = d2_reg[1];
            end
            3'b011: ctx_next.split = SPLIT_TWO;
            3'b101:
            begin
                ctx_next.split = SPLIT_TWO;
                ctx_next.s1 = v2_reg[2];
                ctx_next.s2 = v2_reg[1];
                sd1 = d2_reg[2];
                sd2 = d2_reg[1];
            end
            3'b110:
            begin
                ctx_next.split = SPLIT_TWO;
                ctx_next.s0 = v2_reg[1];
                ctx_next.s1 = v2_reg[2];
                ctx_next.s2 = v2_reg[0];
                sd0 = d2_reg[1];
                sd1 = d2_reg[2];
                sd2 = d2_reg[0];
            end
            3'b111: ctx_next.split = SPLIT_ALL;
        endcase
        if (ctx_next.split == SPLIT_ONE)
        begin
            cut1_next = mk_cut(sd0, sd1);
            cut2_next = mk_cut(sd0, sd2);
        end
        else
        begin
            cut1_next = mk_cut(sd0, sd2);
            cut2_next = mk_cut(sd1, sd2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg   <= v_in;
            p1_reg   <= p1_next;
            off1_reg <= off1_next;
            v2_reg   <= v1_reg;
            d2_reg   <= d2_next;
            ctx_reg  <= ctx_next;
            cut1_reg <= cut1_next;
            cut2_reg <= cut2_next;
        end
    end

    assign ctx_valid = s3_valid_reg;
    assign ctx       = ctx_reg;
    assign cut1      = cut1_reg;
    assign cut2      = cut2_reg;
endmodule

// ===== rtl/tsp_div.sv =====
// Pipelined restoring divider for the two cut fractions, two quotient bits a stage.
`timescale 1ns / 1ps
module tsp_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  tsp_pkg::ctx_t in_ctx,
    input  tsp_pkg::cut_t in_cut1,
    input  tsp_pkg::cut_t in_cut2,
    output logic          out_valid,
    output tsp_pkg::ctx_t out_ctx,
    output tsp_pkg::cut_t out_cut1,
    output tsp_pkg::cut_t out_cut2
);
    import tsp_pkg::*;

    function automatic cut_t div_steps(cut_t c);
        cut_t           r;
        logic [DEN_W:0] r2;
        r = c;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r2 = {r.rem, 1'b0};
            if (r2 >= {1'b0, r.den})
            begin
                r.rem = DEN_W'(r2 - {1'b0, r.den});
                r.q   = {r.q[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                r.rem = r2[DEN_W-1:0];
                r.q   = {r.q[FRAC_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [DIV_STAGES-1:0] valid_reg;
    ctx_t                  ctx_reg [DIV_STAGES];
    cut_t                  c1_reg [DIV_STAGES];
    cut_t                  c2_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic v_prev;
        ctx_t ctx_prev;
        cut_t c1_prev;
        cut_t c2_prev;

        if (k == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign ctx_prev = in_ctx;
            assign c1_prev  = in_cut1;
            assign c2_prev  = in_cut2;
        end
        else
        begin : g_rest
            assign v_prev   = valid_reg[k-1];
            assign ctx_prev = ctx_reg[k-1];
            assign c1_prev  = c1_reg[k-1];
            assign c2_prev  = c2_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[k] <= ctx_prev;
                c1_reg[k]  <= div_steps(c1_prev);
                c2_reg[k]  <= div_steps(c2_prev);
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_ctx   = ctx_reg[DIV_STAGES-1];
    assign out_cut1  = c1_reg[DIV_STAGES-1];
    assign out_cut2  = c2_reg[DIV_STAGES-1];
endmodule

// ===== rtl/tsp_interp.sv =====
// Cut point interpolation: clamp and differences, multiply, add.
`timescale 1ns / 1ps
module tsp_interp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  tsp_pkg::ctx_t    in_ctx,
    input  tsp_pkg::cut_t    in_cut1,
    input  tsp_pkg::cut_t    in_cut2,
    output logic             bundle_valid,
    output tsp_pkg::bundle_t bundle
);
    import tsp_pkg::*;

    function automatic coord_t vcomp(vert_t v, int k);
        coord_t c;
        unique case (k)
            0:       c = v.x;
            1:       c = v.y;
            default: c = v.z;
        endcase
        return c;
    endfunction

    function automatic logic [FRAC_BITS-1:0] clamp_t(cut_t c);
        logic [FRAC_BITS-1:0] t;
        priority if (c.de_zero) t = T_MAX;
        else if (c.q == '0)     t = T_MIN;
        else                    t = c.q;
        return t;
    endfunction

    // stage A
    logic                     a_valid_reg;
    ctx_t                     a_ctx_reg;
    logic [FRAC_BITS-1:0]     t1_reg;
    logic [FRAC_BITS-1:0]     t2_reg;
    logic signed [DIFF_W-1:0] d1_reg [3];
    logic signed [DIFF_W-1:0] d2_reg [3];
    logic signed [DIFF_W-1:0] d1_next [3];
    logic signed [DIFF_W-1:0] d2_next [3];
    vert_t                    e1;
    vert_t                    b2;

    always_comb
    begin
        e1 = (in_ctx.split == SPLIT_ONE) ? in_ctx.s1 : in_ctx.s2;
        b2 = (in_ctx.split == SPLIT_ONE) ? in_ctx.s0 : in_ctx.s1;
        for (int k = 0; k < 3; k++)
        begin
            d1_next[k] = DIFF_W'(vcomp(e1, k)) - DIFF_W'(vcomp(in_ctx.s0, k));
            d2_next[k] = DIFF_W'(vcomp(in_ctx.s2, k)) - DIFF_W'(vcomp(b2, k));
        end
    end

    // stage B
    logic                    b_valid_reg;
    ctx_t                    b_ctx_reg;
    logic signed [MUL_W-1:0] m1_reg [3];
    logic signed [MUL_W-1:0] m2_reg [3];
    logic signed [MUL_W-1:0] m1_next [3];
    logic signed [MUL_W-1:0] m2_next [3];
    logic signed [MUL_W-1:0] t1_ext;
    logic signed [MUL_W-1:0] t2_ext;

    always_comb
    begin
        t1_ext = $signed(MUL_W'({1'b0, t1_reg}));
        t2_ext = $signed(MUL_W'({1'b0, t2_reg}));
        for (int k = 0; k < 3; k++)
        begin
            m1_next[k] = MUL_W'(d1_reg[k]) * t1_ext;
            m2_next[k] = MUL_W'(d2_reg[k]) * t2_ext;
        end
    end

    // stage C
    logic    c_valid_reg;
    bundle_t bundle_reg;
    bundle_t bundle_next;
    vert_t   bb2;
    coord_t  i1c [3];
    coord_t  i2c [3];

    always_comb
    begin
        bb2 = (b_ctx_reg.split == SPLIT_ONE) ? b_ctx_reg.s0 : b_ctx_reg.s1;
        for (int k = 0; k < 3; k++)
        begin
            i1c[k] = vcomp(b_ctx_reg.s0, k) + coord_t'(m1_reg[k][FRAC_BITS +: COORD_W]);
            i2c[k] = vcomp(bb2, k) + coord_t'(m2_reg[k][FRAC_BITS +: COORD_W]);
        end
        bundle_next.split = b_ctx_reg.split;
        bundle_next.s0    = b_ctx_reg.s0;
        bundle_next.s1    = b_ctx_reg.s1;
        bundle_next.s2    = b_ctx_reg.s2;
        bundle_next.i1    = mk_vert(i1c[0], i1c[1], i1c[2]);
        bundle_next.i2    = mk_vert(i2c[0], i2c[1], i2c[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ctx_reg  <= in_ctx;
            t1_reg     <= clamp_t(in_cut1);
            t2_reg     <= clamp_t(in_cut2);
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            b_ctx_reg  <= a_ctx_reg;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            bundle_reg <= bundle_next;
        end
    end

    assign bundle_valid = c_valid_reg;
    assign bundle       = bundle_reg;
endmodule

// ===== rtl/tsp_emit.sv =====
// Output stage: holds one split result and sends its triangles one beat at a time.
`timescale 1ns / 1ps
`include "triangle_plane_splitter_macros.svh"
module tsp_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             bundle_valid,
    input  tsp_pkg::bundle_t bundle,
    input  logic             out_stall,
    output logic             adv,
    output logic             out_valid,
    output tsp_pkg::out_t    out_data
);
    import tsp_pkg::*;

    logic       hold_valid_reg;
    bundle_t    hold_reg;
    logic [1:0] beat_reg;
    logic [1:0] beat_next;
    logic       single;
    logic       final_beat;
    logic       take;
    logic       side;
    vert_t      tp;
    vert_t      tq;
    vert_t      tr;

    assign single     = (hold_reg.split == SPLIT_NONE) || (hold_reg.split == SPLIT_ALL);
    assign final_beat = single || (beat_reg == 2'd2);
    assign take       = hold_valid_reg && !out_stall;
    assign adv        = !hold_valid_reg || (take && final_beat);
    assign beat_next  = adv ? 2'd0 : (take ? beat_reg + 2'd1 : beat_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            beat_reg       <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                hold_valid_reg <= bundle_valid;
            end
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hold_reg <= bundle;
        end
    end

    always_comb
    begin
        side = 1'b0;
        tp   = hold_reg.s0;
        tq   = hold_reg.s1;
        tr   = hold_reg.s2;
        unique case (hold_reg.split)
            SPLIT_NONE: side = 1'b1;
            SPLIT_ALL:  side = 1'b0;
            SPLIT_ONE:
            begin
                unique case (beat_reg)
                    2'd0:
                    begin
                        side = 1'b0;
                        tq = hold_reg.i1;
                        tr = hold_reg.i2;
                    end
                    2'd1:
                    begin
                        side = 1'b1;
                        tp = hold_reg.s1;
                        tq = hold_reg.i2;
                        tr = hold_reg.i1;
                    end
                    default:
                    begin
                        side = 1'b1;
                        tp = hold_reg.s1;
                        tq = hold_reg.i2;
                        tr = hold_reg.s2;
                    end
                endcase
            end
            SPLIT_TWO:
            begin
                unique case (beat_reg)
                    2'd0:
                    begin
                        side = 1'b0;
                        tq = hold_reg.i1;
                        tr = hold_reg.i2;
                    end
                    2'd1:
                    begin
                        side = 1'b0;
                        tq = hold_reg.i2;
                        tr = hold_reg.s1;
                    end
                    default:
                    begin
                        side = 1'b1;
                        tp = hold_reg.s2;
                        tq = hold_reg.i2;
                        tr = hold_reg.i1;
                    end
                endcase
            end
        endcase
    end

    assign out_valid        = hold_valid_reg;
    assign out_data.side    = side;
    assign out_data.out_a_x = tp.x;
    assign out_data.out_a_y = tp.y;
    assign out_data.out_a_z = tp.z;
    assign out_data.out_b_x = tq.x;
    assign out_data.out_b_y = tq.y;
    assign out_data.out_b_z = tq.z;
    assign out_data.out_c_x = tr.x;
    assign out_data.out_c_y = tr.y;
    assign out_data.out_c_z = tr.z;
    assign out_data.last    = final_beat;

    `TSP_ASSERT_IMP(a_beat_range, clk, rst_n, hold_valid_reg, beat_reg != 2'd3)
    `TSP_ASSERT_IMP(a_single_beat, clk, rst_n, hold_valid_reg && single, beat_reg == 2'd0)
    `TSP_ASSERT_NXT(a_stall_hold, clk, rst_n, hold_valid_reg && out_stall, hold_valid_reg && $stable(beat_reg))
endmodule

// ===== bench/triangle_plane_splitter_tb.sv =====
// Testbench for the triangle plane splitter: plane predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

// Scoreboard: predicts the pieces of each accepted triangle and checks returned beats.
class tsp_piece_board;
    typedef logic signed [127:0] wdist_t;

    tsp_pkg::norm_t nx, ny, nz;
    tsp_pkg::offs_t w;
    tsp_pkg::out_t  pieces_due[$];
    int             mismatches;
    int             beats_seen;
    int             splits_seen;

    function new();
        nx = '0;
        ny = '0;
        nz = tsp_pkg::NZ_RESET;
        w = '0;
        mismatches = 0;
        beats_seen = 0;
        splits_seen = 0;
    endfunction

    function void set_plane_reg(tsp_pkg::reg_idx_t idx, logic [31:0] val);
        case (idx)
            tsp_pkg::REG_NX:     nx = val[15:0];
            tsp_pkg::REG_NY:     ny = val[15:0];
            tsp_pkg::REG_NZ:     nz = val[15:0];
            tsp_pkg::REG_OFFSET: w = val;
            default: ;
        endcase
    endfunction

    // exact signed distance, Q.30
    function wdist_t plane_dist(tsp_pkg::vert_t v);
        wdist_t acc;
        acc = wdist_t'(w) * 128'sd16384;
        acc += wdist_t'(nx) * wdist_t'(v.x);
        acc += wdist_t'(ny) * wdist_t'(v.y);
        acc += wdist_t'(nz) * wdist_t'(v.z);
        return acc;
    endfunction

    function wdist_t cut_frac(wdist_t db, wdist_t de);
        wdist_t den, num, q;
        den = de - db;
        num = -db;
        if (den == 0) return 128'sd32768;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) return 128'sd1;
        if (num >= den) return 128'sd65535;
        q = (num <<< 16) / den;
        return (q < 1) ? 128'sd1 : q;
    endfunction

    function tsp_pkg::coord_t lerp_coord(tsp_pkg::coord_t b, tsp_pkg::coord_t e, wdist_t t);
        wdist_t prod;
        prod = ((wdist_t'(e) - wdist_t'(b)) * t) >>> 16;
        return b + tsp_pkg::coord_t'(prod[31:0]);
    endfunction

    function tsp_pkg::vert_t cut_point(tsp_pkg::vert_t b, wdist_t db,
                                       tsp_pkg::vert_t e, wdist_t de);
        tsp_pkg::vert_t p;
        wdist_t t;
        t = cut_frac(db, de);
        p.x = lerp_coord(b.x, e.x, t);
        p.y = lerp_coord(b.y, e.y, t);
        p.z = lerp_coord(b.z, e.z, t);
        return p;
    endfunction

    function void push_piece(logic side, tsp_pkg::vert_t p, tsp_pkg::vert_t q,
                             tsp_pkg::vert_t r, logic last);
        tsp_pkg::out_t o;
        o.side = side;
        o.out_a_x = p.x; o.out_a_y = p.y; o.out_a_z = p.z;
        o.out_b_x = q.x; o.out_b_y = q.y; o.out_b_z = q.z;
        o.out_c_x = r.x; o.out_c_y = r.y; o.out_c_z = r.z;
        o.last = last;
        pieces_due.insert(pieces_due.size(), o);
    endfunction

    // accepted triangle: queue the pieces it must produce
    function void note_triangle(tsp_pkg::in_t t);
        tsp_pkg::vert_t v[3], bv[3], ev[3], i1, i2;
        wdist_t d, bd[3], ed[3];
        int nb, ne;
        nb = 0;
        ne = 0;
        v[0] = tsp_pkg::vert_t'({t.a_x, t.a_y, t.a_z});
        v[1] = tsp_pkg::vert_t'({t.b_x, t.b_y, t.b_z});
        v[2] = tsp_pkg::vert_t'({t.c_x, t.c_y, t.c_z});
        for (int i = 0; i < 3; i++) begin
            d = plane_dist(v[i]);
            if (d < 0) begin
                bv[nb] = v[i]; bd[nb] = d; nb++;
            end else begin
                ev[ne] = v[i]; ed[ne] = d; ne++;
            end
        end
        if (nb == 3) push_piece(1'b0, bv[0], bv[1], bv[2], 1'b1);
        else if (nb == 0) push_piece(1'b1, ev[0], ev[1], ev[2], 1'b1);
        else if (nb == 1) begin
            splits_seen++;
            i1 = cut_point(bv[0], bd[0], ev[0], ed[0]);
            i2 = cut_point(bv[0], bd[0], ev[1], ed[1]);
            push_piece(1'b0, bv[0], i1, i2, 1'b0);
            push_piece(1'b1, ev[0], i2, i1, 1'b0);
            push_piece(1'b1, ev[0], i2, ev[1], 1'b1);
        end else begin
            splits_seen++;
            i1 = cut_point(bv[0], bd[0], ev[0], ed[0]);
            i2 = cut_point(bv[1], bd[1], ev[0], ed[0]);
            push_piece(1'b0, bv[0], i1, i2, 1'b0);
            push_piece(1'b0, bv[0], i2, bv[1], 1'b0);
            push_piece(1'b1, ev[0], i2, i1, 1'b1);
        end
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $error("%s: expected %h, got %h", name, exp_v, act_v);
        end
    endfunction

    function void check_piece(tsp_pkg::out_t o);
        tsp_pkg::out_t e;
        beats_seen++;
        if (pieces_due.size() == 0) begin
            mismatches++;
            $error("unexpected output beat %h", o);
            return;
        end
        e = pieces_due.pop_front();
        cmp_field("side", e.side, o.side);
        cmp_field("out_a_x", e.out_a_x, o.out_a_x);
        cmp_field("out_a_y", e.out_a_y, o.out_a_y);
        cmp_field("out_a_z", e.out_a_z, o.out_a_z);
        cmp_field("out_b_x", e.out_b_x, o.out_b_x);
        cmp_field("out_b_y", e.out_b_y, o.out_b_y);
        cmp_field("out_b_z", e.out_b_z, o.out_b_z);
        cmp_field("out_c_x", e.out_c_x, o.out_c_x);
        cmp_field("out_c_y", e.out_c_y, o.out_c_y);
        cmp_field("out_c_z", e.out_c_z, o.out_c_z);
        cmp_field("last", e.last, o.last);
    endfunction
endclass

module triangle_plane_splitter_tb;
    import tsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;   // well past the pipeline depth
    localparam int ONE = 65536;         // 1.0 in Q16.16

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    tsp_piece_board board;
    int tris_taken = 0;
    int cycles = 0;
    int stall_mode = 0;         // 0 never, 1 random, 2 periodic burst

    triangle_plane_splitter u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // Monitors sample at the rising edge, before the block's own updates land.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            board.note_triangle(in_data);
            tris_taken <= tris_taken + 1;
        end
        if (rst_n && out_valid && !out_stall)
            board.check_piece(out_data);
    end

    // Receiver stall pattern, changed only at falling edges.
    always @(negedge clk) begin
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= (cycles % 23) < 12;
            default: out_stall <= 1'b0;
        endcase
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("triangle_plane_splitter_tb: errors");
            $finish;
        end
    end

    function automatic vert_t vtx(int x, int y, int z);
        return mk_vert(coord_t'(x), coord_t'(y), coord_t'(z));
    endfunction

    function automatic in_t tri3(vert_t a, vert_t b, vert_t c);
        return in_t'({a, b, c});
    endfunction

    // APB write: setup then access phase; the register takes it at the access edge.
    task automatic plane_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_plane_reg(idx, val);
    endtask

    task automatic set_plane(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                             logic [31:0] vw);
        plane_write(REG_NX, {16'h0, vx});
        plane_write(REG_NY, {16'h0, vy});
        plane_write(REG_NZ, {16'h0, vz});
        plane_write(REG_OFFSET, vw);
    endtask

    // Drop valid and hold off until every queued piece has come back.
    // Called at a falling edge, right after the last beat was taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pieces_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Present one beat and hold it until taken; valid stays high for the caller.
    task automatic send_tri(in_t t);
        int seen;
        seen = tris_taken;
        in_valid <= 1'b1;
        in_data <= t;
        do @(negedge clk); while (tris_taken == seen);
    endtask

    function automatic int near_coord();
        return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endfunction

    function automatic in_t random_tri();
        in_t t;
        if ($urandom_range(0, 2) == 0) begin
            t = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom});
        end else begin
            t = tri3(vtx(near_coord(), near_coord(), near_coord()),
                     vtx(near_coord(), near_coord(), near_coord()),
                     vtx(near_coord(), near_coord(), near_coord()));
        end
        return t;
    endfunction

    // Bursts of random length separated by random gaps, plus idle-free runs.
    // Starts at a falling edge so a beat left up by the caller is replaced at once.
    task automatic random_burst_run(int n);
        int sent, burst, gap;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_tri(random_tri());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
        end
    endtask

    task automatic directed_default_plane();
        in_t dir[14];
        // plane is z = 0, so side follows the sign of z
        dir[0] = tri3(vtx(0, 0, ONE), vtx(ONE, 0, 2 * ONE), vtx(0, ONE, 3 * ONE));
        dir[1] = tri3(vtx(0, 0, -ONE), vtx(ONE, 0, -2 * ONE), vtx(0, ONE, -3 * ONE));
        // one begin vertex, in each slot
        dir[2] = tri3(vtx(0, 0, -ONE), vtx(ONE, 0, ONE), vtx(0, ONE, ONE));
        dir[3] = tri3(vtx(0, 0, ONE), vtx(ONE, 0, -ONE), vtx(0, ONE, ONE));
        dir[4] = tri3(vtx(0, 0, ONE), vtx(ONE, 0, ONE), vtx(0, ONE, -ONE));
        // two begin vertices, in each pairing
        dir[5] = tri3(vtx(0, 0, -ONE), vtx(ONE, 0, -ONE), vtx(0, ONE, ONE));
        dir[6] = tri3(vtx(0, 0, -ONE), vtx(ONE, 0, ONE), vtx(0, ONE, -ONE));
        dir[7] = tri3(vtx(0, 0, ONE), vtx(ONE, 0, -ONE), vtx(0, ONE, -ONE));
        // end vertex exactly on the plane: fraction clamps high
        dir[8] = tri3(vtx(0, 0, -ONE), vtx(ONE, 0, 0), vtx(0, ONE, ONE));
        dir[9] = tri3(vtx(0, 0, 0), vtx(ONE, 0, 0), vtx(0, ONE, 0));
        // begin vertex one lsb below, far end: fraction clamps low
        dir[10] = tri3(vtx(5, 7, -1), vtx(-3, 9, 32'h7fffffff), vtx(1, 1, ONE));
        // coordinate extremes, wrap in the cut point
        dir[11] = tri3(vtx(32'h80000000, 32'h7fffffff, 32'h80000000),
                       vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff),
                       vtx(32'h80000000, 32'h80000000, 32'h7fffffff));
        dir[12] = tri3(vtx(32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
                       vtx(32'h80000000, 32'h80000000, 32'h80000000),
                       vtx(-1, -1, -1));
        dir[13] = tri3(vtx(-1, -1, -1), vtx(-1, -1, -1), vtx(-1, -1, -1));
        @(negedge clk);
        foreach (dir[i]) send_tri(dir[i]);
    endtask

    task automatic directed_flat_plane();
        // zero normal: offset sign alone picks the side, pieces never split
        @(negedge clk);
        send_tri(tri3(vtx(ONE, -ONE, 32'h7fffffff), vtx(0, 0, 0),
                      vtx(32'h80000000, 3, -7)));
        send_tri(random_tri());
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase 1: reset plane, directed shapes, no receiver stall
        stall_mode = 0;
        directed_default_plane();
        random_burst_run(50);
        drain();   // sender holds off until every piece is back

        // phase 2: x = 0 plane, random stalls
        set_plane(16'sd16384, 16'sd0, 16'sd0, 32'd0);
        stall_mode = 1;
        random_burst_run(70);
        drain();

        // phase 3: all normal terms and offset at their negative extremes
        set_plane(16'h8000, 16'h8000, 16'h8000, 32'h80000000);
        stall_mode = 2;
        random_burst_run(60);
        drain();

        // phase 4: positive extremes
        set_plane(16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff);
        stall_mode = 1;
        random_burst_run(60);
        drain();

        // phase 5: zero normal, offset -1 then 0
        set_plane(16'h0, 16'h0, 16'h0, 32'hffffffff);
        stall_mode = 0;
        directed_flat_plane();
        drain();
        plane_write(REG_OFFSET, 32'd0);
        directed_flat_plane();
        drain();

        // phase 6: tilted plane with a small offset
        set_plane(16'sd9000, -16'sd12000, 16'sd7000, 32'(2 * ONE));
        stall_mode = 1;
        random_burst_run(90);
        drain();

        // phase 7: random plane
        set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                  32'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE));
        stall_mode = 2;
        random_burst_run(60);
        drain();

        $display("Covered %0d triangles (%0d split) and %0d output beats",
                 tris_taken, board.splits_seen, board.beats_seen);
        $display("over seven plane settings, extremes and zero normal included.");
        if (board.mismatches == 0 && board.pieces_due.size() == 0)
            $display("triangle_plane_splitter_tb: clean");
        else
            $display("triangle_plane_splitter_tb: errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_dist.sv
rtl/tsp_div.sv
rtl/tsp_interp.sv
rtl/tsp_emit.sv
rtl/triangle_plane_splitter.sv
bench/triangle_plane_splitter_tb.sv
